### rtl/core/ccr_pkg.sv
// Shared types, constants and arithmetic helpers of the conservative restriction block.
`default_nettype none
package ccr_pkg;
	localparam int COARSE_CELLS  = 1024;
	localparam int DIMENSIONS    = 3;
	localparam int FRACTION_BITS = 16;
	localparam int CELL_AW       = $clog2(COARSE_CELLS);
	localparam int ACC_W         = 64;
	localparam int STEP_W        = $clog2(ACC_W);
	localparam int ENTRY_W       = 5 * ACC_W;
	localparam int IN_W          = 200;
	localparam int OUT_W         = 176;

	localparam logic [63:0] MAX64     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] VEL_POS   = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] VEL_NEG   = 64'h0000_0000_8000_0000;
	localparam logic [63:0] ENG_LIM   = 64'h4000_0000_0000_0000;
	localparam logic [30:0] RHO_MAX   = 31'h7FFF_FFFF;
	localparam logic        CMD_ACCUM  = 1'b0;
	localparam logic        CMD_FINISH = 1'b1;

	typedef enum logic {ALU_MUL, ALU_DIV} alu_op_t;

	typedef struct packed {
		logic        start;
		alu_op_t     op;
		logic [63:0] x_hi;
		logic [63:0] x_lo;
		logic [63:0] y;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] hi;
		logic [63:0] lo;
	} alu_rsp_t;

	function automatic logic [63:0] mag64(input logic [63:0] x);
		return x[63] ? (64'd0 - x) : x;
	endfunction

	function automatic logic [63:0] sext32(input logic [31:0] x);
		return {{32{x[31]}}, x};
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if ((a[63] == b[63]) && (r[63] != a[63]))
			r = a[63] ? ~MAX64 : MAX64;
		return r;
	endfunction

	// Shifts a 128-bit magnitude right by F or 2F, saturates, applies the sign.
	function automatic logic [63:0] shr_sat(input logic [127:0] p, input logic dbl,
		input logic neg);
		logic [127:0] r;
		logic [63:0]  m;
		r = dbl ? (p >> (2 * FRACTION_BITS)) : (p >> FRACTION_BITS);
		m = (r[127:63] != '0) ? MAX64 : r[63:0];
		return neg ? (64'd0 - m) : m;
	endfunction

	function automatic logic [31:0] sat32(input logic [63:0] r);
		logic [31:0] s;
		if (r[63])
			s = (r < 64'hFFFF_FFFF_8000_0000) ? 32'h8000_0000 : r[31:0];
		else
			s = (r > VEL_POS) ? 32'h7FFF_FFFF : r[31:0];
		return s;
	endfunction
endpackage
`default_nettype wire

### rtl/core/ccr_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module ccr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### rtl/core/ccr_serial_alu.sv
// Bit-serial 64x64 multiplier and 128/64 restoring divider sharing one set of registers.
`default_nettype none
module ccr_serial_alu import ccr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);
	logic              busy_q;
	logic              done_q;
	alu_op_t           op_q;
	logic [STEP_W-1:0] cnt_q;
	logic [63:0]       hi_q;
	logic [63:0]       lo_q;
	logic [63:0]       y_q;
	logic [64:0]       mul_sum;
	logic [63:0]       div_sh;
	logic              div_ge;

	always_comb begin
		mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, y_q} : 65'd0);
		div_sh  = {hi_q[62:0], lo_q[63]};
		div_ge  = hi_q[63] || (div_sh >= y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
			cnt_q  <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
			y_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q  <= req.op;
				y_q   <= req.y;
				cnt_q <= '0;
				// A quotient that cannot fit in 64 bits saturates to all ones.
				if (req.op == ALU_DIV && req.x_hi >= req.y) begin
					hi_q   <= req.x_hi;
					lo_q   <= '1;
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					hi_q   <= (req.op == ALU_MUL) ? 64'd0 : req.x_hi;
					lo_q   <= req.x_lo;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (op_q == ALU_MUL) begin
					hi_q <= mul_sum[64:1];
					lo_q <= {mul_sum[0], lo_q[63:1]};
				end else begin
					hi_q <= div_ge ? (div_sh - y_q) : div_sh;
					lo_q <= {lo_q[62:0], div_ge};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.hi   = hi_q;
	assign rsp.lo   = lo_q;
endmodule
`default_nettype wire

### rtl/core/conservative_cell_restriction_top.sv
// Conservative restriction of fine cells onto a table of coarse-cell sums.
// The input stream (s_axis) carries one command per transfer: tuser 0 adds a
// fine cell's mass, momentum and total energy into its coarse entry; tuser 1
// reads that entry, sends one result transfer on m_axis with density,
// velocity and specific internal energy, and clears the entry.
// All multiplies and divides run through one bit-serial unit. Accumulate
// and finish each use eight operations; an empty cell, a zero volume or a
// saturating division is shorter. The block takes no new transfer until the
// previous command has finished.
// After reset all 1024 table entries are cleared one entry per cycle, and
// s_axis_tready stays low until that pass ends.
// The result sits in an output register; while the receiver stalls the
// block still accepts and processes accumulates, and a finish waits only
// when its result would overwrite one not yet taken.
`default_nettype none
module conservative_cell_restriction_top import ccr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// cell_index, cell_volume, fine_density, fine_velocity_x, _y, _z, fine_energy
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	// command
	input  wire logic             s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// result_index, result_density, result_velocity_x, _y, _z, result_energy, zero pad
	output logic [OUT_W-1:0]      m_axis_tdata,
	// result_valid
	output logic                  m_axis_tuser
);
	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_LOAD,
		S_A_M, S_A_SQ, S_A_MV, S_A_E,
		S_F_RHO, S_F_V, S_F_SQ, S_F_E,
		S_WR, S_OUT
	} state_t;

	state_t             state_q;
	logic [CELL_AW-1:0] clr_q;
	logic               issued_q;
	logic [1:0]         dim_q;
	logic               cmd_q;
	logic [9:0]         idx_q;
	logic [30:0]        vol_q;
	logic [30:0]        dens_q;
	logic [31:0]        vel_q [3];
	logic [31:0]        eng_q;
	logic [63:0]        m_q;
	logic [63:0]        ke_q;
	logic [63:0]        m_sum_q;
	logic [63:0]        mom_q [3];
	logic [63:0]        e_sum_q;
	logic               res_valid_q;
	logic [30:0]        res_rho_q;
	logic [31:0]        res_v_q [3];
	logic [31:0]        res_e_q;
	logic               out_valid_q;
	logic               out_user_q;
	logic [OUT_W-1:0]   out_data_q;

	logic               ok;
	logic               compute;
	logic               dim_last;
	logic [63:0]        vmag_in;
	logic [63:0]        pmag;
	logic [63:0]        rvmag;
	logic [63:0]        emag;
	logic [63:0]        spec;
	logic [127:0]       prod;
	logic [63:0]        qc;
	logic [63:0]        qs;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic               ram_we;
	logic [CELL_AW-1:0] ram_addr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	assign ok       = (32'(idx_q) < COARSE_CELLS);
	assign dim_last = (dim_q == 2'(DIMENSIONS - 1));
	assign vmag_in  = mag64(sext32(vel_q[dim_q]));
	assign pmag     = mag64(mom_q[dim_q]);
	assign rvmag    = mag64(sext32(res_v_q[dim_q]));
	assign emag     = mag64(e_sum_q);
	assign spec     = (sext32(eng_q) << FRACTION_BITS) + (ke_q >> 1);
	assign prod     = {alu_rsp.hi, alu_rsp.lo};

	always_comb begin
		compute = 1'b0;
		alu_req = '{start: 1'b0, op: ALU_MUL, x_hi: 64'd0, x_lo: 64'd0, y: 64'd0};
		unique case (state_q)
			S_A_M: begin
				compute      = 1'b1;
				alu_req.x_lo = {33'd0, dens_q};
				alu_req.y    = {33'd0, vol_q};
			end
			S_A_SQ, S_A_MV: begin
				compute      = 1'b1;
				alu_req.x_lo = vmag_in;
				alu_req.y    = (state_q == S_A_SQ) ? vmag_in : m_q;
			end
			S_A_E: begin
				compute      = 1'b1;
				alu_req.x_lo = mag64(spec);
				alu_req.y    = m_q;
			end
			S_F_RHO: begin
				compute      = 1'b1;
				alu_req.op   = ALU_DIV;
				alu_req.x_lo = m_sum_q;
				alu_req.y    = {33'd0, vol_q};
			end
			S_F_V: begin
				compute      = 1'b1;
				alu_req.op   = ALU_DIV;
				alu_req.x_hi = pmag >> (ACC_W - FRACTION_BITS);
				alu_req.x_lo = pmag << FRACTION_BITS;
				alu_req.y    = m_sum_q;
			end
			S_F_SQ: begin
				compute      = 1'b1;
				alu_req.x_lo = rvmag;
				alu_req.y    = rvmag;
			end
			S_F_E: begin
				compute      = 1'b1;
				alu_req.op   = ALU_DIV;
				alu_req.x_hi = emag >> (ACC_W - FRACTION_BITS);
				alu_req.x_lo = emag << FRACTION_BITS;
				alu_req.y    = m_sum_q;
			end
			default: begin
				compute = 1'b0;
			end
		endcase
		alu_req.start = compute && !issued_q;
	end

	always_comb begin
		if (state_q == S_F_V)
			qc = pmag[63] ? 64'd0 : 64'd0;
		else
			qc = 64'd0;
		if (state_q == S_F_V) begin
			if (mom_q[dim_q][63])
				qc = (alu_rsp.lo > VEL_NEG) ? VEL_NEG : alu_rsp.lo;
			else
				qc = (alu_rsp.lo > VEL_POS) ? VEL_POS : alu_rsp.lo;
			qs = mom_q[dim_q][63] ? (64'd0 - qc) : qc;
		end else begin
			qc = (alu_rsp.lo > ENG_LIM) ? ENG_LIM : alu_rsp.lo;
			qs = e_sum_q[63] ? (64'd0 - qc) : qc;
		end
	end

	assign ram_we    = (state_q == S_CLR) || (state_q == S_WR);
	assign ram_addr  = (state_q == S_CLR) ? clr_q : idx_q[CELL_AW-1:0];
	assign ram_wdata = ((state_q == S_CLR) || (cmd_q == CMD_FINISH)) ? '0 :
		{e_sum_q, mom_q[2], mom_q[1], mom_q[0], m_sum_q};

	ccr_ram #(.WIDTH(ENTRY_W), .DEPTH(COARSE_CELLS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	ccr_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			issued_q    <= 1'b0;
			dim_q       <= '0;
			cmd_q       <= CMD_ACCUM;
			idx_q       <= '0;
			vol_q       <= '0;
			dens_q      <= '0;
			vel_q       <= '{default: '0};
			eng_q       <= '0;
			m_q         <= '0;
			ke_q        <= '0;
			m_sum_q     <= '0;
			mom_q       <= '{default: '0};
			e_sum_q     <= '0;
			res_valid_q <= 1'b0;
			res_rho_q   <= '0;
			res_v_q     <= '{default: '0};
			res_e_q     <= '0;
			out_valid_q <= 1'b0;
			out_user_q  <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// In S_OUT the output register is either reloaded or still holds its result.
			if (m_axis_tready && (state_q != S_OUT))
				out_valid_q <= 1'b0;
			if (alu_req.start)
				issued_q <= 1'b1;
			if (alu_rsp.done)
				issued_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q    <= s_axis_tuser;
						idx_q    <= s_axis_tdata[9:0];
						vol_q    <= s_axis_tdata[40:10];
						dens_q   <= s_axis_tdata[71:41];
						vel_q[0] <= s_axis_tdata[103:72];
						vel_q[1] <= s_axis_tdata[135:104];
						vel_q[2] <= s_axis_tdata[167:136];
						eng_q    <= s_axis_tdata[199:168];
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					m_sum_q     <= ram_rdata[63:0];
					mom_q[0]    <= ram_rdata[127:64];
					mom_q[1]    <= ram_rdata[191:128];
					mom_q[2]    <= ram_rdata[255:192];
					e_sum_q     <= ram_rdata[319:256];
					ke_q        <= '0;
					dim_q       <= '0;
					res_rho_q   <= '0;
					res_v_q     <= '{default: '0};
					res_e_q     <= '0;
					res_valid_q <= ok && ram_rdata[63:0] != '0 && !ram_rdata[63];
					if (cmd_q == CMD_ACCUM)
						state_q <= ok ? S_A_M : S_IDLE;
					else if (!ok)
						state_q <= S_OUT;
					else if (ram_rdata[63:0] == '0 || ram_rdata[63])
						state_q <= S_WR;
					else if (vol_q == '0) begin
						res_rho_q <= RHO_MAX;
						state_q   <= S_F_V;
					end else
						state_q <= S_F_RHO;
				end
				S_A_M: begin
					if (alu_rsp.done) begin
						m_q     <= alu_rsp.lo;
						state_q <= S_A_SQ;
					end
				end
				S_A_SQ: begin
					if (alu_rsp.done) begin
						ke_q    <= ke_q + alu_rsp.lo;
						state_q <= S_A_MV;
					end
				end
				S_A_MV: begin
					if (alu_rsp.done) begin
						mom_q[dim_q] <= sat_add(mom_q[dim_q],
							shr_sat(prod, 1'b0, vel_q[dim_q][31]));
						if (dim_last)
							state_q <= S_A_E;
						else begin
							dim_q   <= dim_q + 1'b1;
							state_q <= S_A_SQ;
						end
					end
				end
				S_A_E: begin
					if (alu_rsp.done) begin
						e_sum_q <= sat_add(e_sum_q, shr_sat(prod, 1'b1, spec[63]));
						m_sum_q <= sat_add(m_sum_q, m_q);
						state_q <= S_WR;
					end
				end
				S_F_RHO: begin
					if (alu_rsp.done) begin
						res_rho_q <= (alu_rsp.lo > {33'd0, RHO_MAX}) ? RHO_MAX :
							alu_rsp.lo[30:0];
						state_q <= S_F_V;
					end
				end
				S_F_V: begin
					if (alu_rsp.done) begin
						res_v_q[dim_q] <= qs[31:0];
						state_q        <= S_F_SQ;
					end
				end
				S_F_SQ: begin
					if (alu_rsp.done) begin
						ke_q <= ke_q + alu_rsp.lo;
						if (dim_last)
							state_q <= S_F_E;
						else begin
							dim_q   <= dim_q + 1'b1;
							state_q <= S_F_V;
						end
					end
				end
				S_F_E: begin
					if (alu_rsp.done) begin
						res_e_q <= sat32(qs - (ke_q >> (FRACTION_BITS + 1)));
						state_q <= S_WR;
					end
				end
				S_WR: begin
					state_q <= (cmd_q == CMD_FINISH) ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_user_q  <= res_valid_q;
						out_data_q  <= {7'd0, res_e_q, res_v_q[2], res_v_q[1], res_v_q[0],
							res_rho_q, idx_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |=> !alu_req.start)
		else $error("arithmetic unit started twice in a row");
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> issued_q)
		else $error("arithmetic result without an issued operation");
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!out_valid_q || m_axis_tready)) |=> m_axis_tvalid)
		else $error("finish result was not presented");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second transfer accepted while the sequencer is busy");
`endif
endmodule
`default_nettype wire

### sim/ccr_scoreboard.sv
// Scoreboard for the conservative restriction block: tracks coarse sums and checks results.
`timescale 1ns / 1ps
module ccr_scoreboard import ccr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	input  wire logic             s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	input  wire logic             s_axis_tuser,
	input  wire logic             m_axis_tvalid,
	input  wire logic             m_axis_tready,
	input  wire logic [OUT_W-1:0] m_axis_tdata,
	input  wire logic             m_axis_tuser,
	output int                    mismatch_count,
	output int                    pending_results
);
	typedef struct packed {
		logic [9:0]  index;
		logic        valid;
		logic [30:0] density;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] vel_z;
		logic [31:0] energy;
	} cell_average_t;

	logic [63:0] mass_tab [COARSE_CELLS];
	logic [63:0] mom_tab [3][COARSE_CELLS];
	logic [63:0] energy_tab [COARSE_CELLS];
	cell_average_t averages_due[$];

	function automatic logic [63:0] magn(input logic [63:0] x);
		return x[63] ? (64'd0 - x) : x;
	endfunction

	function automatic logic [63:0] acc_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			r = a[63] ? 64'h8000_0000_0000_0000 : MAX64;
		return r;
	endfunction

	// Signed product shifted right, truncated toward zero, magnitude saturated.
	function automatic logic [63:0] prod_shift(input logic [63:0] a, input logic [63:0] b,
		input int sh);
		logic [127:0] p;
		logic [63:0]  r;
		p = {64'd0, magn(a)} * {64'd0, magn(b)};
		p = p >> sh;
		r = (p[127:63] != '0) ? MAX64 : p[63:0];
		return (a[63] ^ b[63]) ? (64'd0 - r) : r;
	endfunction

	// Signed (num << F) / den, truncated toward zero and clamped per sign.
	function automatic logic [63:0] scaled_quot(input logic [63:0] num,
		input logic [63:0] den, input logic [63:0] lim_pos, input logic [63:0] lim_neg);
		logic [127:0] q128;
		logic [63:0]  q;
		q128 = ({64'd0, magn(num)} << FRACTION_BITS) / {64'd0, den};
		q = (q128[127:64] != '0) ? '1 : q128[63:0];
		if (num[63])
			return 64'd0 - ((q > lim_neg) ? lim_neg : q);
		return (q > lim_pos) ? lim_pos : q;
	endfunction

	function automatic logic [31:0] clamp32(input logic [63:0] r);
		if (r[63])
			return (r < 64'hFFFF_FFFF_8000_0000) ? 32'h8000_0000 : r[31:0];
		return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
	endfunction

	task automatic add_fine_cell(input logic [IN_W-1:0] d);
		logic [9:0]  idx;
		logic [63:0] m, ke, spec, v, vm;
		idx = d[9:0];
		ke = 0;
		if (idx >= COARSE_CELLS)
			return;
		m = {33'd0, d[71:41]} * {33'd0, d[40:10]};
		for (int k = 0; k < DIMENSIONS && k < 3; k++) begin
			v = {{32{d[72+32*k+31]}}, d[72+32*k +: 32]};
			vm = magn(v);
			ke = ke + vm * vm;
			mom_tab[k][idx] = acc_add(mom_tab[k][idx], prod_shift(m, v, FRACTION_BITS));
		end
		spec = ({{32{d[199]}}, d[199:168]} << FRACTION_BITS) + (ke >> 1);
		mass_tab[idx] = acc_add(mass_tab[idx], m);
		energy_tab[idx] = acc_add(energy_tab[idx], prod_shift(m, spec, 2 * FRACTION_BITS));
	endtask

	task automatic finish_coarse_cell(input logic [IN_W-1:0] d);
		cell_average_t a;
		logic [9:0]    idx;
		logic [63:0]   msum, vol, rho, ke, v, vm, q;
		logic [31:0]   vels [3];
		a = '0;
		idx = d[9:0];
		vol = {33'd0, d[40:10]};
		a.index = idx;
		ke = 0;
		vels = '{default: 32'd0};
		if (idx < COARSE_CELLS) begin
			msum = mass_tab[idx];
			if (msum != 0 && !msum[63]) begin
				if (vol == 0)
					rho = 64'h7FFF_FFFF;
				else begin
					rho = msum / vol;
					if (rho > 64'h7FFF_FFFF)
						rho = 64'h7FFF_FFFF;
				end
				a.valid = 1'b1;
				a.density = rho[30:0];
				for (int k = 0; k < DIMENSIONS && k < 3; k++) begin
					v = scaled_quot(mom_tab[k][idx], msum, 64'h7FFF_FFFF, 64'h8000_0000);
					vm = magn(v);
					ke = ke + vm * vm;
					vels[k] = v[31:0];
				end
				a.vel_x = vels[0];
				a.vel_y = vels[1];
				a.vel_z = vels[2];
				q = scaled_quot(energy_tab[idx], msum, 64'h4000_0000_0000_0000,
					64'h4000_0000_0000_0000);
				a.energy = clamp32(q - (ke >> (FRACTION_BITS + 1)));
			end
			mass_tab[idx] = 0;
			energy_tab[idx] = 0;
			for (int k = 0; k < 3; k++)
				mom_tab[k][idx] = 0;
		end
		averages_due.push_back(a);
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatch_count++;
			$display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
		end
	endtask

	initial begin
		mismatch_count = 0;
		pending_results = 0;
		for (int i = 0; i < COARSE_CELLS; i++) begin
			mass_tab[i] = 0;
			energy_tab[i] = 0;
			for (int k = 0; k < 3; k++)
				mom_tab[k][i] = 0;
		end
	end

	always @(posedge clk) begin
		cell_average_t e;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == CMD_ACCUM)
					add_fine_cell(s_axis_tdata);
				else
					finish_coarse_cell(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (averages_due.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with nothing expected, got %h / %b", $time,
						m_axis_tdata, m_axis_tuser);
				end else begin
					e = averages_due.pop_front();
					compare_field("index", e.index, m_axis_tdata[9:0]);
					compare_field("valid", e.valid, m_axis_tuser);
					compare_field("density", e.density, m_axis_tdata[40:10]);
					compare_field("velocity_x", e.vel_x, m_axis_tdata[72:41]);
					compare_field("velocity_y", e.vel_y, m_axis_tdata[104:73]);
					compare_field("velocity_z", e.vel_z, m_axis_tdata[136:105]);
					compare_field("energy", e.energy, m_axis_tdata[168:137]);
				end
			end
			pending_results = averages_due.size();
		end
	end
endmodule

### sim/testbench.sv
// Top-level testbench: drives fine-cell and finish commands into the block and gives the verdict.
`timescale 1ns / 1ps
module testbench import ccr_pkg::*;;
	localparam int RANDOM_ITEMS = 550;
	localparam int QUIET_ITEMS  = 60;
	localparam longint CYCLE_LIMIT = 2_000_000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             s_axis_tuser = CMD_ACCUM;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tuser;
	logic             quiet = 1'b0;
	int               mismatch_count;
	int               pending_results;
	longint           cycles = 0;

	conservative_cell_restriction_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	ccr_scoreboard i_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.mismatch_count(mismatch_count), .pending_results(pending_results)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: randomly mixed ready stretches and stall bursts until the quiet tail.
	initial begin
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	function automatic logic [31:0] pick_signed();
		case ($urandom_range(0, 6))
			0: return $urandom();
			1: return 32'h0;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
		endcase
	endfunction

	function automatic logic [30:0] pick_unsigned();
		case ($urandom_range(0, 8))
			0: return 31'($urandom());
			1: return 31'h0;
			2: return 31'h7FFF_FFFF;
			default: return 31'($urandom_range(32'h1000, 32'h4_0000));
		endcase
	endfunction

	task automatic send(input logic cmd, input logic [9:0] idx, input logic [30:0] vol,
		input logic [30:0] dens, input logic [31:0] vx, input logic [31:0] vy,
		input logic [31:0] vz, input logic [31:0] eng);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {eng, vz, vy, vx, dens, vol, idx};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_fine(input logic [9:0] idx);
		send(CMD_ACCUM, idx, pick_unsigned(), pick_unsigned(), pick_signed(),
			pick_signed(), pick_signed(), pick_signed());
	endtask

	initial begin
		logic [9:0] coarse_idx;
		int         sent;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, saturation, empty and zero-mass cells, zero volume.
		send(CMD_FINISH, 10'd7, 31'h1_0000, '0, '0, '0, '0, '0);
		send(CMD_ACCUM, 10'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
		send(CMD_ACCUM, 10'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
		send(CMD_ACCUM, 10'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h1, 32'h7FFF_FFFF);
		send(CMD_FINISH, 10'd0, 31'h0, '0, '0, '0, '0, '0);
		send(CMD_ACCUM, 10'd1023, 31'h1_0000, 31'h2_0000, 32'h1_8000, 32'hFFFF_0000,
			32'h0000_4000, 32'h3_0000);
		send(CMD_ACCUM, 10'd1023, 31'h0_8000, 31'h1_0000, 32'hFFFE_0000, 32'h1_0000,
			32'h8000_0000, 32'hFFFF_0000);
		send(CMD_FINISH, 10'd1023, 31'h1, '0, '0, '0, '0, '0);
		send(CMD_ACCUM, 10'd512, 31'h1_0000, 31'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(CMD_FINISH, 10'd512, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(CMD_ACCUM, 10'd3, 31'h1, 31'h1, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		send(CMD_FINISH, 10'd3, 31'h7FFF_FFFF, '0, '0, '0, '0, '0);
		send(CMD_ACCUM, 10'd0, 31'h0, 31'h7FFF_FFFF, 32'h1_0000, 32'h1_0000,
			32'h1_0000, 32'h1_0000);
		send(CMD_FINISH, 10'd0, 31'h1_0000, '0, '0, '0, '0, '0);

		// Random part: fine-cell runs onto one coarse cell, then its finish, or lone commands.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
				quiet <= 1'b1;
			coarse_idx = ($urandom_range(0, 4) == 0) ? 10'($urandom()) :
				10'($urandom_range(0, 15));
			case ($urandom_range(0, 9))
				0: begin
					send(CMD_FINISH, coarse_idx, pick_unsigned(), pick_unsigned(),
						pick_signed(), pick_signed(), pick_signed(), pick_signed());
					sent++;
				end
				1: begin
					send_fine(coarse_idx);
					sent++;
				end
				default: begin
					repeat ($urandom_range(1, 8)) begin
						send_fine(coarse_idx);
						sent++;
					end
					send(CMD_FINISH, coarse_idx, pick_unsigned(), pick_unsigned(),
						pick_signed(), pick_signed(), pick_signed(), pick_signed());
					sent++;
				end
			endcase
		end
		s_axis_tvalid <= 1'b0;
		quiet <= 1'b1;

		while (pending_results != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
